// ===== rtl/core/dtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    localparam int ID_W   = 4;
    localparam int TICK_W = 16;
    localparam int KIND_W = 2;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_ADD_OK,
        ST_ADD_FULL,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_TICK_NEXT,
        ST_TICK_LOOK,
        ST_TICK_MORE,
        ST_TICK_LAST
    } state_t;

    typedef struct packed {
        logic              load;
        logic              rd_pos;
        logic              rd_src;
        logic              rd_head;
        logic              walk_adv;
        logic              src_init;
        logic              src_dec;
        logic              wr_shift;
        logic              wr_ins;
        logic              wr_head;
        logic              pop;
        logic              pend_load;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic full;
        logic empty;
        logic pos_at_cnt;
        logic walk_pass;
        logic src_at_pos;
        logic head_live;
        logic rd_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/dtq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire dtq_pkg::status_t sts,
    output dtq_pkg::cmd_t        cmd
);

    dtq_pkg::state_t state_reg;
    dtq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtq_pkg::ST_IDLE: begin
                if (s_valid) state_next = dtq_pkg::ST_DISPATCH;
            end
            dtq_pkg::ST_DISPATCH: begin
                if (sts.is_tick) begin
                    state_next = sts.empty ? dtq_pkg::ST_IDLE : dtq_pkg::ST_TICK_RD;
                end else begin
                    state_next = sts.full ? dtq_pkg::ST_ADD_FULL : dtq_pkg::ST_WALK_RD;
                end
            end
            dtq_pkg::ST_WALK_RD: begin
                state_next = sts.pos_at_cnt ? dtq_pkg::ST_INS_WR : dtq_pkg::ST_WALK_CHK;
            end
            dtq_pkg::ST_WALK_CHK: begin
                state_next = sts.walk_pass ? dtq_pkg::ST_WALK_RD : dtq_pkg::ST_SHIFT_RD;
            end
            dtq_pkg::ST_SHIFT_RD: state_next = dtq_pkg::ST_SHIFT_WR;
            dtq_pkg::ST_SHIFT_WR: begin
                state_next = sts.src_at_pos ? dtq_pkg::ST_INS_WR : dtq_pkg::ST_SHIFT_RD;
            end
            dtq_pkg::ST_INS_WR: state_next = dtq_pkg::ST_ADD_OK;
            dtq_pkg::ST_ADD_OK, dtq_pkg::ST_ADD_FULL, dtq_pkg::ST_TICK_LAST: begin
                if (sts.out_free) state_next = dtq_pkg::ST_IDLE;
            end
            dtq_pkg::ST_TICK_RD: state_next = dtq_pkg::ST_TICK_CHK;
            dtq_pkg::ST_TICK_CHK: begin
                state_next = sts.head_live ? dtq_pkg::ST_IDLE : dtq_pkg::ST_TICK_NEXT;
            end
            dtq_pkg::ST_TICK_NEXT: begin
                state_next = sts.empty ? dtq_pkg::ST_TICK_LAST : dtq_pkg::ST_TICK_LOOK;
            end
            dtq_pkg::ST_TICK_LOOK: begin
                state_next = sts.rd_zero ? dtq_pkg::ST_TICK_MORE : dtq_pkg::ST_TICK_LAST;
            end
            dtq_pkg::ST_TICK_MORE: begin
                if (sts.out_free) state_next = dtq_pkg::ST_TICK_NEXT;
            end
            default: state_next = dtq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            dtq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            dtq_pkg::ST_WALK_RD: begin
                cmd.rd_pos = !sts.pos_at_cnt;
            end
            dtq_pkg::ST_WALK_CHK: begin
                cmd.walk_adv = sts.walk_pass;
                cmd.src_init = !sts.walk_pass;
            end
            dtq_pkg::ST_SHIFT_RD: cmd.rd_src = 1'b1;
            dtq_pkg::ST_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.src_dec  = !sts.src_at_pos;
            end
            dtq_pkg::ST_INS_WR: cmd.wr_ins = 1'b1;
            dtq_pkg::ST_ADD_OK: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = dtq_pkg::KIND_ACCEPTED;
                cmd.emit_last = 1'b1;
            end
            dtq_pkg::ST_ADD_FULL: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = dtq_pkg::KIND_FULL;
                cmd.emit_last = 1'b1;
            end
            dtq_pkg::ST_TICK_RD: cmd.rd_head = 1'b1;
            dtq_pkg::ST_TICK_CHK: begin
                cmd.wr_head   = sts.head_live;
                cmd.pop       = !sts.head_live;
                cmd.pend_load = !sts.head_live;
            end
            dtq_pkg::ST_TICK_NEXT: cmd.rd_head = !sts.empty;
            dtq_pkg::ST_TICK_MORE: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = dtq_pkg::KIND_EXPIRED;
                cmd.emit_last = 1'b0;
                cmd.pop       = sts.out_free;
                cmd.pend_load = sts.out_free;
            end
            dtq_pkg::ST_TICK_LAST: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = dtq_pkg::KIND_EXPIRED;
                cmd.emit_last = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/dtq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtq_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dtq_pkg::cmd_t                 cmd,
    output dtq_pkg::status_t                   sts,
    input  wire logic                          s_operation,
    input  wire logic [dtq_pkg::ID_W-1:0]      s_process_id,
    input  wire logic [dtq_pkg::TICK_W-1:0]    s_sleep_ticks,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dtq_pkg::KIND_W-1:0]         m_kind,
    output logic [dtq_pkg::ID_W-1:0]           m_woken_id,
    output logic                               m_last
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int ID_W   = dtq_pkg::ID_W;
    localparam int TICK_W = dtq_pkg::TICK_W;
    localparam int ENT_W  = ID_W + TICK_W;

    logic [ENT_W-1:0]  mem [QUEUE_DEPTH];
    logic [ENT_W-1:0]  rd_data_reg;

    logic [IDX_W-1:0]  hp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  src_reg;
    logic [TICK_W-1:0] rem_reg;
    logic              op_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [ID_W-1:0]   pend_reg;

    logic                      m_valid_reg;
    logic [dtq_pkg::KIND_W-1:0] m_kind_reg;
    logic [ID_W-1:0]           m_id_reg;
    logic                      m_last_reg;

    logic [TICK_W-1:0] rd_delta;
    logic [ID_W-1:0]   rd_owner;
    logic [TICK_W-1:0] head_dec;
    logic [TICK_W-1:0] fwd_delta;
    logic [CNT_W-1:0]  src_up;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic              out_free;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hp,
                                              input logic [CNT_W-1:0] l);
        logic [SUM_W-1:0] s;
        s = {1'b0, hp} + SUM_W'(l);
        if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    assign rd_owner  = rd_data_reg[ENT_W-1:TICK_W];
    assign rd_delta  = rd_data_reg[TICK_W-1:0];
    assign head_dec  = (rd_delta == '0) ? rd_delta : rd_delta - TICK_W'(1);
    assign fwd_delta = (src_reg == pos_reg) ? rd_delta - rem_reg : rd_delta;
    assign src_up    = src_reg + CNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        rd_en   = cmd.rd_pos || cmd.rd_src || cmd.rd_head;
        rd_addr = hp_reg;
        if (cmd.rd_pos) rd_addr = phys(hp_reg, pos_reg);
        if (cmd.rd_src) rd_addr = phys(hp_reg, src_reg);
    end

    always_comb begin
        wr_en   = cmd.wr_shift || cmd.wr_ins || cmd.wr_head;
        wr_addr = hp_reg;
        wr_data = {rd_owner, head_dec};
        priority if (cmd.wr_shift) begin
            wr_addr = phys(hp_reg, src_up);
            wr_data = {rd_owner, fwd_delta};
        end else if (cmd.wr_ins) begin
            wr_addr = phys(hp_reg, pos_reg);
            wr_data = {pid_reg, rem_reg};
        end else begin
            wr_addr = hp_reg;
            wr_data = {rd_owner, head_dec};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_ins) cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.pop) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                hp_reg  <= (hp_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : hp_reg + IDX_W'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            pid_reg <= s_process_id;
            rem_reg <= s_sleep_ticks;
            pos_reg <= '0;
        end
        if (cmd.walk_adv) begin
            rem_reg <= rem_reg - rd_delta;
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (cmd.src_init) src_reg <= cnt_reg - CNT_W'(1);
        if (cmd.src_dec)  src_reg <= src_reg - CNT_W'(1);
        if (cmd.pend_load) pend_reg <= rd_owner;
        if (cmd.emit) begin
            m_kind_reg <= cmd.emit_kind;
            m_id_reg   <= (cmd.emit_kind == dtq_pkg::KIND_EXPIRED) ? pend_reg : pid_reg;
            m_last_reg <= cmd.emit_last;
        end
    end

    always_comb begin
        sts            = '0;
        sts.is_tick    = (op_reg == dtq_pkg::OP_TICK);
        sts.full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
        sts.empty      = (cnt_reg == '0);
        sts.pos_at_cnt = (pos_reg == cnt_reg);
        sts.walk_pass  = (rd_delta <= rem_reg);
        sts.src_at_pos = (src_reg == pos_reg);
        sts.head_live  = (head_dec != '0);
        sts.rd_zero    = (rd_delta == '0);
        sts.out_free   = out_free;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_woken_id = m_id_reg;
    assign m_last     = m_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count past depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> cnt_reg != '0)
        else $error("pop on empty queue");

    a_ins_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_ins |-> cnt_reg != CNT_W'(QUEUE_DEPTH))
        else $error("insert into full queue");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result overwrites pending item");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("pop did not drop count");

endmodule

`default_nettype wire

// ===== rtl/core/delta_timer_queue_top.sv =====
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_operation, s_process_id, s_sleep_ticks
// m_      | out       | m_valid / m_ready  | m_kind, m_woken_id, m_last
//
// One item at a time on one circular memory with one read and one write per cycle.
// An add walks past earlier entries and moves later entries up a slot when it lands
// before one; a tick decrements the head delta and pops each entry that expires.
// Reset clears count, head pointer and output valid; the entry memory is not cleared.
// A stalled m_ready holds the result register and pauses the controller.
`timescale 1ns / 1ps
`default_nettype none

module delta_timer_queue_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_operation,
    input  wire logic [dtq_pkg::ID_W-1:0]   s_process_id,
    input  wire logic [dtq_pkg::TICK_W-1:0] s_sleep_ticks,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [dtq_pkg::KIND_W-1:0]      m_kind,
    output logic [dtq_pkg::ID_W-1:0]        m_woken_id,
    output logic                            m_last
);

    dtq_pkg::cmd_t    cmd;
    dtq_pkg::status_t sts;

    dtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_process_id  (s_process_id),
        .s_sleep_ticks (s_sleep_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_woken_id    (m_woken_id),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
